[src/rmq_pkg.sv]
// shared types and constants for the rotation matrix to quaternion block
// no dependencies; used by rmq_div, the top level and the testbench
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int OUT_W         = 16;
    localparam int NUM_ELEM      = 9;
    localparam int NUM_LANE      = 4;
    localparam int DIFF_W        = 17;
    localparam int QUO_W         = 17;

    // quotient clamp: 2^16, which is 4.0 at the default 14 fraction bits
    localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(1) << 16;
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7fff;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 16'h8000;

    // output lane codes
    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_Z = 2'd2;
    localparam logic [1:0] LANE_W = 2'd3;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic [NUM_LANE-1:0][DIFF_W-1:0] d;
        logic [1:0]                      main;
        logic                            degen;
    } sq_side_t;

    typedef struct packed {
        logic [NUM_LANE-1:0] neg;
        logic [1:0]          main;
        logic                degen;
        logic [OUT_W-1:0]    main_val;
    } dv_side_t;

endpackage

[src/rmq_isqrt.sv]
// pipelined integer square root, one root bit per stage, with sideband
// depends on nothing but its parameters
`timescale 1ns / 1ps

module rmq_isqrt #(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [IN_W/2-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int SW = IN_W / 2;

    logic [SW+1:0]     rem_reg  [SW];
    logic [SW+1:0]     rem_next [SW];
    logic [SW-1:0]     root_reg [SW];
    logic [SW-1:0]     root_next[SW];
    logic [IN_W-1:0]   v_reg    [SW];
    logic [IN_W-1:0]   v_next   [SW];
    logic [SIDE_W-1:0] side_reg [SW];
    logic [SW-1:0]     vld_reg;

    for (genvar t = 0; t < SW; t++) begin : g_stage
        logic [SW+1:0]   rem_in;
        logic [SW-1:0]   root_in;
        logic [IN_W-1:0] v_in;
        logic [SW+1:0]   rem_sh;
        logic [SW+1:0]   trial;

        if (t == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = radicand;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[t-1];
            assign root_in = root_reg[t-1];
            assign v_in    = v_reg[t-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[SW-1:0], v_in[IN_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            v_next[t] = v_in << 2;
            if (rem_sh >= trial)
            begin
                rem_next[t]  = rem_sh - trial;
                root_next[t] = {root_in[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next[t]  = rem_sh;
                root_next[t] = {root_in[SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[t] <= 1'b0;
            else if (ce)
                vld_reg[t] <= (t == 0) ? in_valid : vld_reg[(t == 0) ? 0 : t-1];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[t]  <= rem_next[t];
                root_reg[t] <= root_next[t];
                v_reg[t]    <= v_next[t];
                side_reg[t] <= (t == 0) ? in_side : side_reg[(t == 0) ? 0 : t-1];
            end
        end
    end

    assign out_valid = vld_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_side  = side_reg[SW-1];

endmodule

[src/rmq_div.sv]
// four-lane restoring divider computing (mag * 2^frac + s) / (2 s), clamped
// to QUO_MAX (2^16); one quotient bit per stage after the first; uses rmq_pkg
`timescale 1ns / 1ps

module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int SW        = 16,
    parameter int SIDE_W    = 8
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 ce,
    input  logic                                                 in_valid,
    input  logic [SW-1:0]                                        s,
    input  logic [rmq_pkg::NUM_LANE-1:0][rmq_pkg::DIFF_W-1:0]    mag,
    input  logic [SIDE_W-1:0]                                    in_side,
    output logic                                                 out_valid,
    output logic [rmq_pkg::NUM_LANE-1:0][rmq_pkg::QUO_W-1:0]     quo,
    output logic [SIDE_W-1:0]                                    out_side
);

    localparam int NL = rmq_pkg::NUM_LANE;
    localparam int QB = rmq_pkg::QUO_W;
    localparam int NS = QB + 1;
    localparam int NW = rmq_pkg::DIFF_W + FRAC_BITS + 1;
    localparam int DW = SW + 1;
    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [NL-1:0][CW-1:0] rem_reg  [NS];
    logic [NL-1:0][CW-1:0] rem_next [NS];
    logic [NL-1:0][QB-1:0] quo_reg  [NS];
    logic [NL-1:0][QB-1:0] quo_next [NS];
    logic [NL-1:0]         ovf_reg  [NS];
    logic [NL-1:0]         ovf_next [NS];
    logic [DW-1:0]         dv_reg   [NS];
    logic [SIDE_W-1:0]     side_reg [NS];
    logic [NS-1:0]         vld_reg;

    for (genvar t = 0; t < NS; t++) begin : g_stage
        if (t == 0) begin : g_first
            logic [DW-1:0] dvs;
            logic [CW-1:0] num [NL];
            always_comb
            begin
                dvs = {s, 1'b0};
                for (int l = 0; l < NL; l++)
                begin
                    num[l]         = (CW'(mag[l]) << FRAC_BITS) + CW'(s);
                    rem_next[t][l] = num[l];
                    quo_next[t][l] = '0;
                    ovf_next[t][l] = num[l] >= (CW'(dvs) << QB);
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    dv_reg[t]   <= dvs;
                    side_reg[t] <= in_side;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[t] <= 1'b0;
                else if (ce)
                    vld_reg[t] <= in_valid;
            end
        end
        else begin : g_rest
            localparam int B = QB - t;
            logic [CW-1:0] dsh;
            always_comb
            begin
                dsh = CW'(dv_reg[t-1]) << B;
                for (int l = 0; l < NL; l++)
                begin
                    ovf_next[t][l] = ovf_reg[t-1][l];
                    if (!ovf_reg[t-1][l] && rem_reg[t-1][l] >= dsh)
                    begin
                        rem_next[t][l] = rem_reg[t-1][l] - dsh;
                        quo_next[t][l] = quo_reg[t-1][l] | (QB'(1) << B);
                    end
                    else
                    begin
                        rem_next[t][l] = rem_reg[t-1][l];
                        quo_next[t][l] = quo_reg[t-1][l];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    dv_reg[t]   <= dv_reg[t-1];
                    side_reg[t] <= side_reg[t-1];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[t] <= 1'b0;
                else if (ce)
                    vld_reg[t] <= vld_reg[t-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[t] <= rem_next[t];
                quo_reg[t] <= quo_next[t];
                ovf_reg[t] <= ovf_next[t];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (ovf_reg[NS-1][l] || quo_reg[NS-1][l] > rmq_pkg::QUO_MAX)
                quo[l] = rmq_pkg::QUO_MAX;
            else
                quo[l] = quo_reg[NS-1][l];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[src/rotation_matrix_to_quaternion.sv]
// rotation matrix to unit quaternion, top level: front end, fifo, assertions
// depends on rmq_pkg, rmq_isqrt and rmq_div
`timescale 1ns / 1ps

// channel  | direction | handshake                      | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: m00..m22, 16 bits each
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: quat_x..quat_w, tuser: degenerate
//
// one matrix per cycle while the pipeline advances; SW = half the radicand width
// (16 at 14 fraction bits) sets the bit-serial root stages. results then go to the
// divider stages and a two-entry output fifo; the pipeline advances whenever
// the fifo is not full, so input stalls only when two results wait downstream.
// reset clears valid bits and fifo pointers; payload registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic [0:0]   m_axis_tuser    // degenerate
);

    localparam int EW   = rmq_pkg::ELEM_W;
    localparam int NE   = rmq_pkg::NUM_ELEM;
    localparam int NL   = rmq_pkg::NUM_LANE;
    localparam int DFW  = rmq_pkg::DIFF_W;
    localparam int OW   = rmq_pkg::OUT_W;
    localparam int QW   = rmq_pkg::QUO_W;
    localparam int R_W  = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
    localparam int RADW = R_W - 1 + FRAC_BITS;
    localparam int RADE = RADW + (RADW % 2);
    localparam int SW   = RADE / 2;
    localparam int RES_W = NL * OW + 1;
    localparam logic signed [R_W-1:0] ONE_R = R_W'(1) << FRAC_BITS;

    logic ce;

    // ---------------- stage 1: trace and axis pick ----------------
    rmq_pkg::elem_t       m_in [NE];
    logic signed [EW+1:0] trace;
    logic                 i1;
    rmq_pkg::elem_t       dmax;
    rmq_pkg::elem_t       m1_reg [NE];
    logic                 tpos1_reg;
    logic [1:0]           sel1_reg;
    logic                 v1_reg;

    always_comb
    begin
        for (int n = 0; n < NE; n++)
            m_in[n] = rmq_pkg::elem_t'(s_axis_tdata[EW*n +: EW]);
        trace = (EW+2)'(m_in[0]) + (EW+2)'(m_in[4]) + (EW+2)'(m_in[8]);
        i1    = m_in[4] > m_in[0];
        dmax  = i1 ? m_in[4] : m_in[0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m1_reg    <= m_in;
            tpos1_reg <= trace > 0;
            if (m_in[8] > dmax)
                sel1_reg <= rmq_pkg::LANE_Z;
            else
                sel1_reg <= i1 ? rmq_pkg::LANE_Y : rmq_pkg::LANE_X;
        end
    end

    // ---------------- stage 2: radicand and off-diagonal terms ----------------
    logic signed [R_W-1:0] e0, e4, e8;
    logic signed [R_W-1:0] r_next;
    rmq_pkg::sq_side_t     side2_next;
    logic signed [R_W-1:0] r2_reg;
    rmq_pkg::sq_side_t     side2_reg;
    logic                  v2_reg;

    function automatic logic [DFW-1:0] dsub(rmq_pkg::elem_t a, rmq_pkg::elem_t b);
        return DFW'(a) - DFW'(b);
    endfunction

    function automatic logic [DFW-1:0] dadd(rmq_pkg::elem_t a, rmq_pkg::elem_t b);
        return DFW'(a) + DFW'(b);
    endfunction

    always_comb
    begin
        e0 = R_W'(m1_reg[0]);
        e4 = R_W'(m1_reg[4]);
        e8 = R_W'(m1_reg[8]);
        side2_next.d = '0;
        if (tpos1_reg)
        begin
            r_next = e0 + e4 + e8 + ONE_R;
            side2_next.main = rmq_pkg::LANE_W;
            side2_next.d[rmq_pkg::LANE_X] = dsub(m1_reg[7], m1_reg[5]);
            side2_next.d[rmq_pkg::LANE_Y] = dsub(m1_reg[2], m1_reg[6]);
            side2_next.d[rmq_pkg::LANE_Z] = dsub(m1_reg[3], m1_reg[1]);
        end
        else
        begin
            case (sel1_reg)
                rmq_pkg::LANE_X:
                begin
                    r_next = e0 - e4 - e8 + ONE_R;
                    side2_next.main = rmq_pkg::LANE_X;
                    side2_next.d[rmq_pkg::LANE_W] = dsub(m1_reg[7], m1_reg[5]);
                    side2_next.d[rmq_pkg::LANE_Y] = dadd(m1_reg[3], m1_reg[1]);
                    side2_next.d[rmq_pkg::LANE_Z] = dadd(m1_reg[6], m1_reg[2]);
                end
                rmq_pkg::LANE_Y:
                begin
                    r_next = e4 - e8 - e0 + ONE_R;
                    side2_next.main = rmq_pkg::LANE_Y;
                    side2_next.d[rmq_pkg::LANE_W] = dsub(m1_reg[2], m1_reg[6]);
                    side2_next.d[rmq_pkg::LANE_Z] = dadd(m1_reg[7], m1_reg[5]);
                    side2_next.d[rmq_pkg::LANE_X] = dadd(m1_reg[1], m1_reg[3]);
                end
                default:
                begin
                    r_next = e8 - e0 - e4 + ONE_R;
                    side2_next.main = rmq_pkg::LANE_Z;
                    side2_next.d[rmq_pkg::LANE_W] = dsub(m1_reg[3], m1_reg[1]);
                    side2_next.d[rmq_pkg::LANE_X] = dadd(m1_reg[2], m1_reg[6]);
                    side2_next.d[rmq_pkg::LANE_Y] = dadd(m1_reg[5], m1_reg[7]);
                end
            endcase
        end
        // only a non-rotation input can get here with a trace path off
        side2_next.degen = !tpos1_reg && (r_next <= 0);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r2_reg    <= r_next;
            side2_reg <= side2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // ---------------- square root ----------------
    logic [RADE-1:0]   radicand;
    logic              sq_valid;
    logic [SW-1:0]     sq_root;
    rmq_pkg::sq_side_t sq_side;

    assign radicand = side2_reg.degen ? '0 : (RADE'(r2_reg[R_W-2:0]) << FRAC_BITS);

    rmq_isqrt #(
        .IN_W   (RADE),
        .SIDE_W ($bits(rmq_pkg::sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v2_reg),
        .radicand  (radicand),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- division ----------------
    logic [SW:0]                  s_inc;
    logic [SW-1:0]                half;
    logic [NL-1:0][DFW-1:0]       mag;
    rmq_pkg::dv_side_t            dv_in;
    logic                         dv_valid;
    logic [NL-1:0][QW-1:0]        quo;
    rmq_pkg::dv_side_t            dv_side;

    always_comb
    begin
        s_inc = {1'b0, sq_root} + (SW+1)'(1);
        half  = s_inc[SW:1];
        dv_in.main  = sq_side.main;
        dv_in.degen = sq_side.degen;
        if (32'(half) > 32'(rmq_pkg::OUT_POS_MAX))
            dv_in.main_val = rmq_pkg::OUT_POS_MAX;
        else
            dv_in.main_val = OW'(half);
        for (int l = 0; l < NL; l++)
        begin
            dv_in.neg[l] = sq_side.d[l][DFW-1];
            mag[l] = dv_in.neg[l] ? (DFW'(0) - sq_side.d[l]) : sq_side.d[l];
        end
    end

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW),
        .SIDE_W    ($bits(rmq_pkg::dv_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .s         (sq_root),
        .mag       (mag),
        .in_side   (dv_in),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (dv_side)
    );

    // ---------------- sign, saturation and output fifo ----------------
    logic [NL-1:0][OW-1:0] lane;
    logic [RES_W-1:0]      res;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (dv_side.degen)
                lane[l] = '0;
            else if (dv_side.main == 2'(l))
                lane[l] = dv_side.main_val;
            else if (dv_side.neg[l])
                lane[l] = (quo[l] >= QW'(32768)) ? rmq_pkg::OUT_NEG_MAX
                                                 : OW'(QW'(0) - quo[l]);
            else
                lane[l] = (quo[l] > QW'(32767)) ? rmq_pkg::OUT_POS_MAX : OW'(quo[l]);
        end
        res = {dv_side.degen, lane};
    end

    logic [RES_W-1:0] fifo_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign ce            = (count_reg != 2'd2);
    assign s_axis_tready = ce;
    assign push          = ce && dv_valid;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = fifo_reg[rd_ptr_reg][RES_W-2:0];
    assign m_axis_tuser  = fifo_reg[rd_ptr_reg][RES_W-1 -: 1];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output fifo count out of range");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result carries nonzero data");

    a_trace_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && side2_reg.main == rmq_pkg::LANE_W |-> !side2_reg.degen)
        else $error("positive trace flagged degenerate");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid && !sq_side.degen |-> sq_root != '0)
        else $error("zero root on a valid radicand");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> $stable(fifo_reg[0]) && $stable(fifo_reg[1]))
        else $error("full fifo overwritten");

endmodule

[tb/rotation_matrix_to_quaternion_test.sv]
// testbench for rotation_matrix_to_quaternion: random and directed matrices,
// predicted quaternions checked in order; depends on rmq_pkg and the block
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;

    localparam int FB    = rmq_pkg::FRAC_BITS_DEF;
    localparam int ONE   = 1 << FB;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
        logic        degen;
    } quat_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    logic [143:0] pending_mats[$];
    quat_t        expected_quats[$];
    int           errors = 0;
    int           cycles = 0;
    int           sent = 0;
    int           got = 0;
    int           degen_seen = 0;
    bit           hold_off;
    bit           calm;

    rotation_matrix_to_quaternion dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // d * ONE / (2 s), nearest with halves away from zero, clamped to 4.0 (65536)
    function automatic longint half_over_root(longint d, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FB) + s) / (2 * s);
        if (q > 65536)
            q = 65536;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic quat_t matrix_to_quat(logic [143:0] data);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint r;
        longint unsigned s;
        int i;
        int j;
        int k;
        quat_t res;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                m[a][b] = longint'($signed(data[(a*3+b)*16 +: 16]));
        q = '{0, 0, 0, 0};
        res.degen = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            r = tr + ONE;
            s = int_root(longint'(r) << FB);
            q[3] = (s + 1) >> 1;
            q[0] = half_over_root(m[2][1] - m[1][2], s);
            q[1] = half_over_root(m[0][2] - m[2][0], s);
            q[2] = half_over_root(m[1][0] - m[0][1], s);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            r = m[i][i] - m[j][j] - m[k][k] + ONE;
            s = (r > 0) ? int_root(longint'(r) << FB) : 0;
            if (s == 0)
                res.degen = 1'b1;
            else
            begin
                q[i] = (s + 1) >> 1;
                q[3] = half_over_root(m[k][j] - m[j][k], s);
                q[j] = half_over_root(m[j][i] + m[i][j], s);
                q[k] = half_over_root(m[k][i] + m[i][k], s);
            end
        end
        res.x = clamp16(q[0]);
        res.y = clamp16(q[1]);
        res.z = clamp16(q[2]);
        res.w = clamp16(q[3]);
        return res;
    endfunction

    function automatic logic [143:0] pack_mat(int e[9]);
        logic [143:0] v;
        for (int n = 0; n < 9; n++)
            v[n*16 +: 16] = e[n][15:0];
        return v;
    endfunction

    // rotation about one axis by an angle, with a small random perturbation
    function automatic logic [143:0] axis_rotation(int ax, real ang, int jitter);
        real c;
        real sn;
        int e[9];
        int j;
        int k;
        c = $cos(ang);
        sn = $sin(ang);
        j = (ax + 1) % 3;
        k = (j + 1) % 3;
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        e[ax*4] = ONE;
        e[j*4] = $rtoi(c * ONE);
        e[k*4] = $rtoi(c * ONE);
        e[j*3+k] = -$rtoi(sn * ONE);
        e[k*3+j] = $rtoi(sn * ONE);
        for (int n = 0; n < 9; n++)
            e[n] = e[n] + $urandom_range(2 * jitter) - jitter;
        for (int n = 0; n < 9; n++)
            if (e[n] > 32767)
                e[n] = 32767;
            else if (e[n] < -32768)
                e[n] = -32768;
        return pack_mat(e);
    endfunction

    // driver: one request per accepted matrix, valid held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_quats.push_back(matrix_to_quat(s_axis_tdata));
                sent++;
            end
            if (pending_mats.size() != 0 && !hold_off
                && (calm || $urandom_range(99) >= 14))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_mats.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        quat_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got++;
                if (expected_quats.size() == 0)
                begin
                    $error("result with no matrix pending: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_quats.pop_front();
                    degen_seen += want.degen;
                    if (m_axis_tdata[15:0] !== want.x)
                    begin
                        $error("quat_x expected %h got %h", want.x, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:16] !== want.y)
                    begin
                        $error("quat_y expected %h got %h", want.y, m_axis_tdata[31:16]);
                        errors++;
                    end
                    if (m_axis_tdata[47:32] !== want.z)
                    begin
                        $error("quat_z expected %h got %h", want.z, m_axis_tdata[47:32]);
                        errors++;
                    end
                    if (m_axis_tdata[63:48] !== want.w)
                    begin
                        $error("quat_w expected %h got %h", want.w, m_axis_tdata[63:48]);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.degen)
                    begin
                        $error("degenerate expected %b got %b", want.degen,
                               m_axis_tuser[0]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= calm || $urandom_range(99) >= 14;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("rotation_matrix_to_quaternion_test: errors");
            $finish;
        end
    end

    initial
    begin
        int e[9];
        hold_off = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;

        // directed: identity, each axis case, degenerate, extremes, ties
        pending_mats.push_back(pack_mat('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
        pending_mats.push_back(pack_mat('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
        pending_mats.push_back(pack_mat('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}));
        pending_mats.push_back(pack_mat('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}));
        pending_mats.push_back(pack_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        pending_mats.push_back(pack_mat('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
        pending_mats.push_back(pack_mat('{-ONE, 5, 7, 9, -ONE, 3, 1, 2, -ONE}));
        pending_mats.push_back(pack_mat('{32767, 32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767}));
        pending_mats.push_back(pack_mat('{-32768, -32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768}));
        pending_mats.push_back(pack_mat('{-32768, 32767, -32768, 32767, -32768,
                                          32767, -32768, 32767, -32768}));
        pending_mats.push_back(pack_mat('{32767, -32768, 32767, -32768, -32768,
                                          32767, 32767, -32768, -32768}));
        pending_mats.push_back(pack_mat('{1, 0, 0, 0, 0, 0, 0, 0, -1}));
        pending_mats.push_back(pack_mat('{0, 100, 0, -100, 0, 0, 0, 0, 0}));
        pending_mats.push_back(pack_mat('{-100, 30000, -30000, 0, -100, 30000,
                                          30000, -30000, -200}));
        pending_mats.push_back(pack_mat('{-ONE, 0, 0, 0, -32768, 0, 0, 0, -32768}));
        for (int a = 0; a < 3; a++)
            pending_mats.push_back(axis_rotation(a, 3.14159265, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_mats.size() != 0 || s_axis_tvalid)
            @(posedge clk);

        // hold off until the pipeline drains
        hold_off = 1'b1;
        while (expected_quats.size() != 0)
            @(posedge clk);
        hold_off = 1'b0;

        for (int n = 0; n < 600; n++)
        begin
            if ($urandom_range(99) < 75)
                pending_mats.push_back(axis_rotation($urandom_range(2),
                    ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159265,
                    $urandom_range(3) == 0 ? 2000 : 3));
            else
            begin
                for (int b = 0; b < 9; b++)
                    e[b] = $signed(16'($urandom));
                pending_mats.push_back(pack_mat(e));
            end
            if (n == 200)
            begin
                calm = 1'b1;
                while (pending_mats.size() != 0)
                    @(posedge clk);
                calm = 1'b0;
            end
        end
        while (pending_mats.size() != 0 || s_axis_tvalid || expected_quats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
                 sent, got, degen_seen);
        $display("covered all pivot axes, saturation, and random stalls on both sides");
        if (errors == 0 && expected_quats.size() == 0)
            $display("rotation_matrix_to_quaternion_test: clean");
        else
            $display("rotation_matrix_to_quaternion_test: errors");
        $finish;
    end

endmodule
